@@ sv/b64d_pkg.sv @@
// Shared types, status codes and character decode helpers for the base64 decoder.
`default_nettype none

package b64d_pkg;

   // Final status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_BAD_CHAR   = 2'd1;
   localparam logic [1:0] STATUS_BAD_LENGTH = 2'd2;

   // Sextet base values of the alphabet ranges
   localparam logic [5:0] LOWER_BASE = 6'd26;
   localparam logic [5:0] DIGIT_BASE = 6'd52;
   localparam logic [5:0] PLUS_CODE  = 6'd62;
   localparam logic [5:0] SLASH_CODE = 6'd63;

   // Decoded character class
   typedef struct packed {
      logic       invalid;
      logic       pad;
      logic [5:0] value;
   } class_type;

   // One emit job: up to six bytes, first byte in the top bits
   typedef struct packed {
      logic [47:0] data;
      logic [2:0]  nbytes;
      logic        fin;
      logic [1:0]  status;
   } job_type;

   // Whitespace that is skipped in the text
   function automatic logic is_space(input logic [7:0] ch);
      return (ch == 8'h0A) || (ch == 8'h0D) || (ch == 8'h20) || (ch == 8'h09);
   endfunction

   // Map an ASCII character to its sextet, flagging '=' and invalid codes
   function automatic class_type classify(input logic [7:0] ch);
      class_type c;
      logic [7:0] d;
      c = '{invalid: 1'b0, pad: 1'b0, value: 6'd0};
      d = 8'd0;
      if (ch >= 8'h41 && ch <= 8'h5A) begin
         d = ch - 8'h41;
         c.value = d[5:0];
      end else if (ch >= 8'h61 && ch <= 8'h7A) begin
         d = ch - 8'h61;
         c.value = d[5:0] + LOWER_BASE;
      end else if (ch >= 8'h30 && ch <= 8'h39) begin
         d = ch - 8'h30;
         c.value = d[5:0] + DIGIT_BASE;
      end else if (ch == 8'h2B) begin
         c.value = PLUS_CODE;
      end else if (ch == 8'h2F) begin
         c.value = SLASH_CODE;
      end else if (ch == 8'h3D) begin
         c.pad = 1'b1;
      end else begin
         c.invalid = 1'b1;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ sv/b64d_front.sv @@
// Front end: classifies characters, collects groups and issues emit jobs.
`default_nettype none

module b64d_front
   import b64d_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    beat,        // input beat accepted this cycle
   input  wire logic [7:0] ch,
   input  wire logic    last,
   output logic         push,
   output job_type      job
);

   logic [17:0] bits_ff, bits_in;
   logic [1:0]  pos_ff, pos_in;
   logic [1:0]  pad_ff, pad_in;
   logic [23:0] held_ff, held_in;
   logic [1:0]  held_pad_ff, held_pad_in;
   logic        held_valid_ff, held_valid_in;
   logic        err_ff, err_in;

   class_type   cls;
   logic        active;
   logic        take;
   logic        complete;
   logic [23:0] full;
   logic [1:0]  pad_cur;
   logic [1:0]  n_fin;

   // Classify and collect
   always_comb begin
      cls      = classify(ch);
      active   = !is_space(ch) && !err_ff;
      take     = active && !cls.invalid;
      complete = take && (pos_ff == 2'd3);
      full     = {bits_ff, cls.value};

      pad_cur = pad_ff;
      if (take && cls.pad && pos_ff == 2'd2) pad_cur[0] = 1'b1;
      if (take && cls.pad && pos_ff == 2'd3) pad_cur[1] = 1'b1;

      err_in        = err_ff || (active && cls.invalid);
      bits_in       = bits_ff;
      pos_in        = pos_ff;
      pad_in        = pad_ff;
      held_in       = held_ff;
      held_pad_in   = held_pad_ff;
      held_valid_in = held_valid_ff;

      if (take && !complete) begin
         bits_in = {bits_ff[11:0], cls.value};
         pos_in  = pos_ff + 2'd1;
         pad_in  = pad_cur;
      end else if (complete) begin
         bits_in       = 18'd0;
         pos_in        = 2'd0;
         pad_in        = 2'd0;
         held_in       = full;
         held_pad_in   = pad_cur;
         held_valid_in = 1'b1;
      end

      // Bytes kept from the final group
      n_fin = 2'd3 - {1'b0, held_pad_in[0]} - {1'b0, held_pad_in[1]};

      // Job selection
      push = 1'b0;
      job  = '{data: 48'd0, nbytes: 3'd0, fin: 1'b0, status: STATUS_OK};
      if (beat) begin
         if (last) begin
            push    = 1'b1;
            job.fin = 1'b1;
            if (err_in) begin
               job.status = STATUS_BAD_CHAR;
            end else if (pos_in != 2'd0) begin
               job.status = STATUS_BAD_LENGTH;
            end else if (held_valid_in) begin
               if (complete && held_valid_ff) begin
                  job.data   = {held_ff, full};
                  job.nbytes = 3'd3 + {1'b0, n_fin};
               end else begin
                  job.data   = {held_in, 24'd0};
                  job.nbytes = {1'b0, n_fin};
               end
            end
         end else if (complete && held_valid_ff) begin
            push       = 1'b1;
            job.data   = {held_ff, 24'd0};
            job.nbytes = 3'd3;
         end
      end
   end

   // State registers; end of text returns to the reset state
   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff       <= 18'd0;
         pos_ff        <= 2'd0;
         pad_ff        <= 2'd0;
         held_ff       <= 24'd0;
         held_pad_ff   <= 2'd0;
         held_valid_ff <= 1'b0;
         err_ff        <= 1'b0;
      end else if (beat && last) begin
         bits_ff       <= 18'd0;
         pos_ff        <= 2'd0;
         pad_ff        <= 2'd0;
         held_ff       <= 24'd0;
         held_pad_ff   <= 2'd0;
         held_valid_ff <= 1'b0;
         err_ff        <= 1'b0;
      end else if (beat) begin
         bits_ff       <= bits_in;
         pos_ff        <= pos_in;
         pad_ff        <= pad_in;
         held_ff       <= held_in;
         held_pad_ff   <= held_pad_in;
         held_valid_ff <= held_valid_in;
         err_ff        <= err_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/b64d_queue.sv @@
// Small job queue between the front end and the byte emitter.
`default_nettype none

module b64d_queue
   import b64d_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output job_type      head_job,
   output logic         empty,
   output logic         full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   // Pointer and fill count
   always_comb begin
      empty    = (count_ff == '0);
      full     = (count_ff == DEPTH_CNT);
      do_push  = push && !full;
      do_pop   = pop && !empty;
      head_job = mem_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;

      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_job;
   end

endmodule

`default_nettype wire

@@ sv/b64d_back.sv @@
// Back end: expands jobs into result beats, at most one byte per beat.
`default_nettype none

module b64d_back
   import b64d_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire job_type head_job,
   input  wire logic    queue_empty,
   output logic         pop,
   input  wire logic    out_ready,
   output logic         out_valid,
   output logic [7:0]   out_byte,
   output logic         out_has_byte,
   output logic         out_final,
   output logic [1:0]   out_status
);

   logic        valid_ff, valid_in;
   logic [47:0] data_ff, data_in;
   logic [2:0]  nbytes_ff, nbytes_in;
   logic        fin_ff, fin_in;
   logic [1:0]  status_ff, status_in;
   logic        last_beat;

   // Beat fields straight from the work register
   always_comb begin
      last_beat    = (nbytes_ff <= 3'd1);
      out_valid    = valid_ff;
      out_byte     = data_ff[47:40];
      out_has_byte = (nbytes_ff != 3'd0);
      out_final    = fin_ff && last_beat;
      out_status   = out_final ? status_ff : STATUS_OK;
   end

   // Shift to next byte or load next job
   always_comb begin
      pop       = !queue_empty && (!valid_ff || (out_ready && last_beat));
      valid_in  = valid_ff;
      data_in   = data_ff;
      nbytes_in = nbytes_ff;
      fin_in    = fin_ff;
      status_in = status_ff;
      if (pop) begin
         valid_in  = 1'b1;
         data_in   = head_job.data;
         nbytes_in = head_job.nbytes;
         fin_in    = head_job.fin;
         status_in = head_job.status;
      end else if (valid_ff && out_ready) begin
         if (last_beat) begin
            valid_in = 1'b0;
         end else begin
            data_in   = {data_ff[39:0], 8'd0};
            nbytes_in = nbytes_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff   <= data_in;
      nbytes_ff <= nbytes_in;
      fin_ff    <= fin_in;
      status_ff <= status_in;
   end

endmodule

`default_nettype wire

@@ sv/base64_stream_decoder.sv @@
// Base64 stream decoder top level: front end, job queue and byte emitter.
//
// Usage: base64 text enters on the req_ channel, one character per beat, with
// req_tlast on the final character of a text. Whitespace is skipped. Decoded
// bytes leave on the rsp_ channel, one byte per beat; rsp_tuser carries the
// has-byte flag and the final status, and rsp_tlast marks the last beat of
// a text. A status other than ok means bytes already delivered are void.
// Throughput: one character per cycle while the queue has room; four characters
// give at most three bytes. The front end decides each character in the accepting
// cycle and queues emit jobs; the emitter drives one byte per cycle from its work
// register while rsp_tready is high, and each byte passes through the queue and
// the work register after the character that releases it. The last group is held
// until req_tlast, so it follows the end marker. Reset clears all group state, the
// queue and the emitter. When the receiver stalls, the emitter holds its beat and
// the queue fills; req_tready drops once the QUEUE_DEPTH-entry queue is full.
`default_nettype none

module base64_stream_decoder
   import b64d_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] text_byte
   input  wire logic       req_tlast,   // end_of_text
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] data_byte
   output logic [2:0]      rsp_tuser,   // [0] has_byte, [2:1] status
   output logic            rsp_tlast    // is_final
);

   logic    beat;
   logic    push;
   job_type push_job;
   job_type head_job;
   logic    q_empty, q_full;
   logic    pop;
   logic    has_byte;
   logic [1:0] status;

   assign req_tready = !q_full;
   assign beat       = req_tvalid && req_tready;

   b64d_front u_front (
      .clock (clock),
      .reset (reset),
      .beat  (beat),
      .ch    (req_tdata),
      .last  (req_tlast),
      .push  (push),
      .job   (push_job)
   );

   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   b64d_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_job     (head_job),
      .queue_empty  (q_empty),
      .pop          (pop),
      .out_ready    (rsp_tready),
      .out_valid    (rsp_tvalid),
      .out_byte     (rsp_tdata),
      .out_has_byte (has_byte),
      .out_final    (rsp_tlast),
      .out_status   (status)
   );

   assign rsp_tuser = {status, has_byte};

endmodule

`default_nettype wire
